@@ rtl/core/biu_pkg.sv @@
// Shared types and constants for the block interval union table.
// Used by biu_cmp, biu_acc, block_interval_union_table and the testbench; depends on nothing.
`timescale 1ns / 1ps

package biu_pkg;

    // Virtual offset layout: block offset above, in-block offset below.
    localparam int VO_W    = 64;
    localparam int BLK_W   = 48;
    localparam int OFF_W   = 16;
    localparam int DELTA_W = 55;

    // Input word commands.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    typedef logic [VO_W-1:0]           t_vo;
    typedef logic [BLK_W-1:0]          t_blk;
    typedef logic [OFF_W-1:0]          t_off;
    typedef logic signed [DELTA_W-1:0] t_delta;

    // One stored interval.
    typedef struct packed {
        t_vo start;
        t_vo stop;
    } t_entry;

    // Block order of a stored interval against the query.
    typedef enum logic [1:0] {
        ORD_BEFORE,
        ORD_SHARE,
        ORD_AFTER
    } t_order;

    // Everything the compare unit reports about one stored interval.
    typedef struct packed {
        t_order order;
        logic   covers;
        logic   start_lt;
        logic   stop_gt;
    } t_cmp_res;

    // Commands to the byte-estimate accumulator.
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_CLR,
        ACC_EST,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HIT,
        S_RM,
        S_INS,
        S_EMIT,
        S_DRAIN
    } t_state;

endpackage

@@ rtl/core/biu_cmp.sv @@
// Shared compare unit: relates one stored interval to the query interval.
// Depends on biu_pkg.
`timescale 1ns / 1ps

module biu_cmp (
    input  biu_pkg::t_entry   i_entry,
    input  biu_pkg::t_vo      i_qry_start,
    input  biu_pkg::t_vo      i_qry_stop,
    output biu_pkg::t_cmp_res o_res
);

    biu_pkg::t_blk eu_blk;
    biu_pkg::t_blk ev_blk;
    biu_pkg::t_blk qu_blk;
    biu_pkg::t_blk qv_blk;
    logic          ev_off_zero;
    logic          qv_off_zero;
    logic          is_before;
    logic          is_after;

    // Split both intervals into block and in-block parts.
    assign eu_blk      = i_entry.start[biu_pkg::VO_W-1:biu_pkg::OFF_W];
    assign ev_blk      = i_entry.stop[biu_pkg::VO_W-1:biu_pkg::OFF_W];
    assign qu_blk      = i_qry_start[biu_pkg::VO_W-1:biu_pkg::OFF_W];
    assign qv_blk      = i_qry_stop[biu_pkg::VO_W-1:biu_pkg::OFF_W];
    assign ev_off_zero = (i_entry.stop[biu_pkg::OFF_W-1:0] == '0);
    assign qv_off_zero = (i_qry_stop[biu_pkg::OFF_W-1:0] == '0);

    // The stored interval lies wholly before or wholly after the query.
    assign is_before = (ev_blk < qu_blk) || ((ev_blk == qu_blk) && ev_off_zero);
    assign is_after  = (qv_blk < eu_blk) || ((qv_blk == eu_blk) && qv_off_zero);

    always_comb begin
        if (is_before) begin
            o_res.order = biu_pkg::ORD_BEFORE;
        end else if (is_after) begin
            o_res.order = biu_pkg::ORD_AFTER;
        end else begin
            o_res.order = biu_pkg::ORD_SHARE;
        end
        // The stored interval holds every block of the query.
        o_res.covers   = (eu_blk <= qu_blk) &&
                         ((qv_blk < ev_blk) || ((qv_blk == ev_blk) && !ev_off_zero));
        // Full-offset compares for widening the query.
        o_res.start_lt = (i_entry.start < i_qry_start);
        o_res.stop_gt  = (i_entry.stop > i_qry_stop);
    end

endmodule

@@ rtl/core/biu_acc.sv @@
// Byte-estimate unit: forms the estimate of one interval and keeps the running delta.
// Depends on biu_pkg.
`timescale 1ns / 1ps

module biu_acc #(
    parameter int AVG_BLOCK_BYTES = 16000
) (
    input  logic             i_clk,
    input  biu_pkg::t_acc_op i_op,
    input  biu_pkg::t_vo     i_start,
    input  biu_pkg::t_vo     i_stop,
    output biu_pkg::t_delta  o_sum
);

    localparam int PAD_W = biu_pkg::DELTA_W - biu_pkg::BLK_W;

    biu_pkg::t_delta r_est;
    biu_pkg::t_delta n_est;
    biu_pkg::t_delta r_sum;
    biu_pkg::t_delta n_sum;
    biu_pkg::t_delta span;

    // Block distance, plus an average block when the end lies inside a block.
    assign span = biu_pkg::t_delta'({{PAD_W{1'b0}}, i_stop[biu_pkg::VO_W-1:biu_pkg::OFF_W]})
                - biu_pkg::t_delta'({{PAD_W{1'b0}}, i_start[biu_pkg::VO_W-1:biu_pkg::OFF_W]});

    always_comb begin
        n_est = r_est;
        n_sum = r_sum;
        case (i_op)
            biu_pkg::ACC_CLR: begin
                n_sum = '0;
            end
            biu_pkg::ACC_EST: begin
                if (i_stop[biu_pkg::OFF_W-1:0] != '0) begin
                    n_est = span + biu_pkg::t_delta'(AVG_BLOCK_BYTES);
                end else begin
                    n_est = span;
                end
            end
            biu_pkg::ACC_ADD: begin
                n_sum = r_sum + r_est;
            end
            biu_pkg::ACC_SUB: begin
                n_sum = r_sum - r_est;
            end
            default: begin
                n_sum = r_sum;
            end
        endcase
    end

    // Estimate and sum registers; the sequencer clears the sum on every new word.
    always_ff @(posedge i_clk) begin
        r_est <= n_est;
        r_sum <= n_sum;
    end

    assign o_sum = r_sum;

endmodule

@@ rtl/core/block_interval_union_table.sv @@
// Block interval union table: keeps an ascending table of disjoint compressed-block
// intervals; depends on biu_pkg, biu_cmp and biu_acc.
`timescale 1ns / 1ps

// An insert word walks the table through a single memory read port and one shared
// compare unit, one stored entry a cycle. A pass that finds no shared block reads
// every stored entry once; each merge adds a further pass plus a move of each later
// entry down by one place to close the gap at the removed place, and storing the
// result moves entries up from the top down to open a gap at the insert place before
// the result word is handed out. The input is stalled throughout an insert, until the
// block is back in idle. A drain word hands out one entry a cycle once the registered
// read of its first entry has returned, following output stalls.
// The table needs no clearing pass after reset; the block is ready at once.
module block_interval_union_table #(
    parameter int TABLE_DEPTH     = 32,
    parameter int AVG_BLOCK_BYTES = 16000
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_cmd,
    input  logic [63:0]           i_chunk_begin,
    input  logic [63:0]           i_chunk_end,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [54:0]    o_size_delta,
    output logic [63:0]           o_out_begin,
    output logic [63:0]           o_out_end,
    output logic                  o_entry_valid,
    output logic                  o_last,
    output logic                  o_overflow
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE      = CW'(1);

    // Table storage and its registered read port.
    biu_pkg::t_entry r_mem [TABLE_DEPTH];
    biu_pkg::t_entry r_rdata;
    logic            mem_re;
    logic [IW-1:0]   mem_raddr;
    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    biu_pkg::t_entry mem_wdata;

    // Sequencer and table bookkeeping.
    biu_pkg::t_state r_state;
    biu_pkg::t_state n_state;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   n_cnt;
    logic [CW-1:0]   r_idx;
    logic [CW-1:0]   n_idx;
    logic [CW-1:0]   r_chk;
    logic [CW-1:0]   n_chk;
    logic            r_chk_vld;
    logic            n_chk_vld;
    logic [CW-1:0]   r_pos;
    logic [CW-1:0]   n_pos;
    logic            r_pos_fnd;
    logic            n_pos_fnd;
    logic            r_merged;
    logic            n_merged;
    logic            r_ovf;
    logic            n_ovf;

    // Query interval and the stored interval that shares a block with it.
    biu_pkg::t_vo    r_qu;
    biu_pkg::t_vo    n_qu;
    biu_pkg::t_vo    r_qv;
    biu_pkg::t_vo    n_qv;
    biu_pkg::t_entry r_hit;
    biu_pkg::t_entry n_hit;
    biu_pkg::t_cmp_res r_hit_res;
    biu_pkg::t_cmp_res n_hit_res;

    // Output register.
    logic            r_out_vld;
    logic            n_out_vld;
    biu_pkg::t_delta r_o_delta;
    biu_pkg::t_delta n_o_delta;
    biu_pkg::t_vo    r_o_begin;
    biu_pkg::t_vo    n_o_begin;
    biu_pkg::t_vo    r_o_end;
    biu_pkg::t_vo    n_o_end;
    logic            r_o_ev;
    logic            n_o_ev;
    logic            r_o_last;
    logic            n_o_last;
    logic            r_o_ovf;
    logic            n_o_ovf;

    // Shared units.
    biu_pkg::t_cmp_res cmp_res;
    biu_pkg::t_acc_op  acc_op;
    biu_pkg::t_vo      acc_start;
    biu_pkg::t_vo      acc_stop;
    biu_pkg::t_delta   acc_sum;

    // Decision terms.
    logic in_take;
    logic out_free;
    logic scan_hit;
    logic scan_done;
    logic rm_done;
    logic ins_done;
    logic dr_take;
    logic dr_last;

    biu_cmp u_cmp (
        .i_entry     (r_rdata),
        .i_qry_start (r_qu),
        .i_qry_stop  (r_qv),
        .o_res       (cmp_res)
    );

    biu_acc #(
        .AVG_BLOCK_BYTES (AVG_BLOCK_BYTES)
    ) u_acc (
        .i_clk   (i_clk),
        .i_op    (acc_op),
        .i_start (acc_start),
        .i_stop  (acc_stop),
        .o_sum   (acc_sum)
    );

    // Handshake and decision terms.
    assign o_in_stall = (r_state != biu_pkg::S_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_vld || !i_out_stall;
    assign scan_hit   = r_chk_vld && (cmp_res.order == biu_pkg::ORD_SHARE);
    assign scan_done  = !r_chk_vld && (r_idx >= r_cnt);
    assign rm_done    = !r_chk_vld && (r_idx >= r_cnt);
    assign ins_done   = !r_chk_vld && (r_idx == r_pos);
    assign dr_take    = r_chk_vld && out_free;
    assign dr_last    = dr_take && (r_chk == r_cnt - ONE);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            biu_pkg::S_IDLE: begin
                if (in_take) begin
                    if (i_cmd == biu_pkg::CMD_INSERT) begin
                        n_state = biu_pkg::S_SCAN;
                    end else if (r_cnt == '0) begin
                        n_state = biu_pkg::S_EMIT;
                    end else begin
                        n_state = biu_pkg::S_DRAIN;
                    end
                end
            end
            biu_pkg::S_SCAN: begin
                if (scan_hit) begin
                    n_state = biu_pkg::S_HIT;
                end else if (scan_done) begin
                    if ((r_cnt == FULL_CNT) && !r_merged) begin
                        n_state = biu_pkg::S_EMIT;
                    end else begin
                        n_state = biu_pkg::S_INS;
                    end
                end
            end
            biu_pkg::S_HIT: begin
                if (r_hit_res.covers) begin
                    n_state = biu_pkg::S_EMIT;
                end else begin
                    n_state = biu_pkg::S_RM;
                end
            end
            biu_pkg::S_RM: begin
                if (rm_done) begin
                    n_state = biu_pkg::S_SCAN;
                end
            end
            biu_pkg::S_INS: begin
                if (ins_done) begin
                    n_state = biu_pkg::S_EMIT;
                end
            end
            biu_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = biu_pkg::S_IDLE;
                end
            end
            biu_pkg::S_DRAIN: begin
                if (dr_last) begin
                    n_state = biu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = biu_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath control per state.
    always_comb begin
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_chk      = r_chk;
        n_chk_vld  = r_chk_vld;
        n_pos      = r_pos;
        n_pos_fnd  = r_pos_fnd;
        n_merged   = r_merged;
        n_ovf      = r_ovf;
        n_qu       = r_qu;
        n_qv       = r_qv;
        n_hit      = r_hit;
        n_hit_res  = r_hit_res;
        n_out_vld  = r_out_vld && i_out_stall;
        n_o_delta  = r_o_delta;
        n_o_begin  = r_o_begin;
        n_o_end    = r_o_end;
        n_o_ev     = r_o_ev;
        n_o_last   = r_o_last;
        n_o_ovf    = r_o_ovf;
        mem_re     = 1'b0;
        mem_raddr  = r_idx[IW-1:0];
        mem_we     = 1'b0;
        mem_waddr  = r_chk[IW-1:0];
        mem_wdata  = r_rdata;
        acc_op     = biu_pkg::ACC_HOLD;
        acc_start  = r_qu;
        acc_stop   = r_qv;

        case (r_state)
            // Take a word and prepare the first pass over the table.
            biu_pkg::S_IDLE: begin
                if (in_take) begin
                    n_qu      = i_chunk_begin;
                    n_qv      = i_chunk_end;
                    n_merged  = 1'b0;
                    n_ovf     = 1'b0;
                    n_idx     = '0;
                    n_chk_vld = 1'b0;
                    n_pos_fnd = 1'b0;
                    acc_op    = biu_pkg::ACC_CLR;
                end
            end

            // Walk the table looking for the first entry that shares a block.
            biu_pkg::S_SCAN: begin
                if (r_chk_vld && !r_pos_fnd && (cmp_res.order != biu_pkg::ORD_BEFORE)) begin
                    n_pos     = r_chk;
                    n_pos_fnd = 1'b1;
                end
                if (scan_hit) begin
                    n_hit     = r_rdata;
                    n_hit_res = cmp_res;
                    n_idx     = r_chk + ONE;
                    n_chk_vld = 1'b0;
                end else if (r_idx < r_cnt) begin
                    mem_re    = 1'b1;
                    n_chk     = r_idx;
                    n_chk_vld = 1'b1;
                    n_idx     = r_idx + ONE;
                end else begin
                    n_chk_vld = 1'b0;
                end
                if (scan_done) begin
                    if ((r_cnt == FULL_CNT) && !r_merged) begin
                        n_ovf  = 1'b1;
                        acc_op = biu_pkg::ACC_CLR;
                    end else begin
                        acc_op = biu_pkg::ACC_EST;
                        n_idx  = r_cnt;
                        if (!r_pos_fnd) begin
                            n_pos = r_cnt;
                        end
                    end
                end
            end

            // Widen the query with the found entry unless it already holds it.
            biu_pkg::S_HIT: begin
                if (!r_hit_res.covers) begin
                    acc_op    = biu_pkg::ACC_EST;
                    acc_start = r_hit.start;
                    acc_stop  = r_hit.stop;
                    n_merged  = 1'b1;
                    if (r_hit_res.start_lt) begin
                        n_qu = r_hit.start;
                    end
                    if (r_hit_res.stop_gt) begin
                        n_qv = r_hit.stop;
                    end
                end
            end

            // Close the gap: move each later entry down by one place.
            biu_pkg::S_RM: begin
                if (r_chk_vld) begin
                    mem_we = 1'b1;
                end
                if (r_idx < r_cnt) begin
                    mem_re    = 1'b1;
                    n_chk     = r_idx - ONE;
                    n_chk_vld = 1'b1;
                    n_idx     = r_idx + ONE;
                end else begin
                    n_chk_vld = 1'b0;
                end
                if (rm_done) begin
                    acc_op    = biu_pkg::ACC_SUB;
                    n_cnt     = r_cnt - ONE;
                    n_idx     = '0;
                    n_pos_fnd = 1'b0;
                end
            end

            // Open a gap at the insert place from the top down, then store the query.
            biu_pkg::S_INS: begin
                if (r_chk_vld) begin
                    mem_we = 1'b1;
                end
                if (r_idx > r_pos) begin
                    mem_re    = 1'b1;
                    n_idx     = r_idx - ONE;
                    mem_raddr = n_idx[IW-1:0];
                    n_chk     = r_idx;
                    n_chk_vld = 1'b1;
                end else begin
                    n_chk_vld = 1'b0;
                end
                if (ins_done) begin
                    mem_we          = 1'b1;
                    mem_waddr       = r_pos[IW-1:0];
                    mem_wdata.start = r_qu;
                    mem_wdata.stop  = r_qv;
                    n_cnt           = r_cnt + ONE;
                    acc_op          = biu_pkg::ACC_ADD;
                end
            end

            // Hand out the single result word of an insert or an empty drain.
            biu_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_o_delta = acc_sum;
                    n_o_begin = '0;
                    n_o_end   = '0;
                    n_o_ev    = 1'b0;
                    n_o_last  = 1'b1;
                    n_o_ovf   = r_ovf;
                end
            end

            // Stream the table out in order, one entry a cycle while the output is not stalled.
            biu_pkg::S_DRAIN: begin
                if (dr_take) begin
                    n_out_vld = 1'b1;
                    n_o_delta = '0;
                    n_o_begin = r_rdata.start;
                    n_o_end   = r_rdata.stop;
                    n_o_ev    = 1'b1;
                    n_o_last  = (r_chk == r_cnt - ONE);
                    n_o_ovf   = 1'b0;
                end
                if ((!r_chk_vld || dr_take) && (r_idx < r_cnt)) begin
                    mem_re    = 1'b1;
                    n_chk     = r_idx;
                    n_chk_vld = 1'b1;
                    n_idx     = r_idx + ONE;
                end else if (dr_take) begin
                    n_chk_vld = 1'b0;
                end
                if (dr_last) begin
                    n_cnt     = '0;
                    n_chk_vld = 1'b0;
                end
            end

            default: begin
                n_chk_vld = 1'b0;
            end
        endcase
    end

    // Table memory: one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= biu_pkg::S_IDLE;
            r_cnt     <= '0;
            r_chk_vld <= 1'b0;
            r_pos_fnd <= 1'b0;
            r_merged  <= 1'b0;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_chk_vld <= n_chk_vld;
            r_pos_fnd <= n_pos_fnd;
            r_merged  <= n_merged;
            r_ovf     <= n_ovf;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload and pointer registers.
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_chk     <= n_chk;
        r_pos     <= n_pos;
        r_qu      <= n_qu;
        r_qv      <= n_qv;
        r_hit     <= n_hit;
        r_hit_res <= n_hit_res;
        r_o_delta <= n_o_delta;
        r_o_begin <= n_o_begin;
        r_o_end   <= n_o_end;
        r_o_ev    <= n_o_ev;
        r_o_last  <= n_o_last;
        r_o_ovf   <= n_o_ovf;
    end

    assign o_out_valid   = r_out_vld;
    assign o_size_delta  = r_o_delta;
    assign o_out_begin   = r_o_begin;
    assign o_out_end     = r_o_end;
    assign o_entry_valid = r_o_ev;
    assign o_last        = r_o_last;
    assign o_overflow    = r_o_ovf;

    // The entry count never exceeds the table depth.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("entry count beyond table depth");

    // A rejected insert only happens on a full table that nothing was merged from.
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == biu_pkg::S_EMIT) && r_ovf |-> (r_cnt == FULL_CNT) && !r_merged)
        else $error("overflow reported on a table with room");

    // An overflow word carries no delta and no entry.
    a_ovf_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> (o_size_delta == '0) && !o_entry_valid && o_last)
        else $error("overflow word carries payload");

    // Words without an entry always close their item.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_entry_valid |-> o_last)
        else $error("insert word not marked last");

    // No read is left pending once the sequencer is back at rest.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == biu_pkg::S_IDLE) |-> !r_chk_vld)
        else $error("pending read while idle");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for block_interval_union_table: drives insert and drain words,
// predicts every result word with its own copy of the interval table and checks it.
// Depends on biu_pkg and the block_interval_union_table RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int TBL_DEPTH = 32;
    localparam int AVG_BYTES = 16000;

    // One result word as the block hands it out.
    typedef struct packed {
        biu_pkg::t_delta size_delta;
        biu_pkg::t_vo    out_begin;
        biu_pkg::t_vo    out_end;
        logic            entry_valid;
        logic            last;
        logic            overflow;
    } t_table_word;

    // Interval table predictor and the queue of result words it expects.
    class interval_scoreboard;
        biu_pkg::t_vo tab_start [TBL_DEPTH];
        biu_pkg::t_vo tab_stop  [TBL_DEPTH];
        int           n_entries;
        t_table_word  expected_words[$];
        int           error_count;

        function new();
            n_entries   = 0;
            error_count = 0;
        endfunction

        // Where the stored interval a lies against the query b, by blocks.
        function biu_pkg::t_order order_of(biu_pkg::t_vo au, biu_pkg::t_vo av,
                                           biu_pkg::t_vo bu, biu_pkg::t_vo bv);
            if (av[63:16] < bu[63:16] || (av[63:16] == bu[63:16] && av[15:0] == 0))
                return biu_pkg::ORD_BEFORE;
            if (bv[63:16] < au[63:16] || (bv[63:16] == au[63:16] && bv[15:0] == 0))
                return biu_pkg::ORD_AFTER;
            return biu_pkg::ORD_SHARE;
        endfunction

        // True when the query's blocks lie within the stored interval's blocks.
        function bit spans(biu_pkg::t_vo tu, biu_pkg::t_vo tv,
                           biu_pkg::t_vo qu, biu_pkg::t_vo qv);
            return tu[63:16] <= qu[63:16] &&
                   (qv[63:16] < tv[63:16] || (qv[63:16] == tv[63:16] && tv[15:0] != 0));
        endfunction

        function longint byte_estimate(biu_pkg::t_vo u, biu_pkg::t_vo v);
            longint e;
            e = longint'({16'd0, v[63:16]}) - longint'({16'd0, u[63:16]});
            if (v[15:0] != 0)
                e += AVG_BYTES;
            return e;
        endfunction

        function void drop_entry(int idx);
            int k;
            for (k = idx; k + 1 < n_entries; k++) begin
                tab_start[k] = tab_start[k + 1];
                tab_stop[k]  = tab_stop[k + 1];
            end
            n_entries--;
        endfunction

        function void insert_interval(biu_pkg::t_vo b, biu_pkg::t_vo e);
            t_table_word  r;
            biu_pkg::t_vo qu, qv;
            longint       removed, diff;
            bit           merged, done;
            int           hit, i, pos, k;
            r       = '0;
            r.last  = 1'b1;
            qu      = b;
            qv      = e;
            removed = 0;
            merged  = 0;
            done    = 0;
            while (!done) begin
                hit = -1;
                for (i = 0; i < n_entries; i++)
                    if (hit < 0 &&
                        order_of(tab_start[i], tab_stop[i], qu, qv) == biu_pkg::ORD_SHARE)
                        hit = i;
                if (hit >= 0) begin
                    if (spans(tab_start[hit], tab_stop[hit], qu, qv)) begin
                        // Already covered: earlier removals stay removed.
                        diff         = -removed;
                        r.size_delta = diff[54:0];
                        done         = 1;
                    end else begin
                        removed += byte_estimate(tab_start[hit], tab_stop[hit]);
                        if (tab_start[hit] < qu) qu = tab_start[hit];
                        if (tab_stop[hit] > qv) qv = tab_stop[hit];
                        drop_entry(hit);
                        merged = 1;
                    end
                end else if (n_entries >= TBL_DEPTH && !merged) begin
                    r.overflow = 1'b1;
                    done       = 1;
                end else begin
                    pos = 0;
                    while (pos < n_entries &&
                           order_of(tab_start[pos], tab_stop[pos], qu, qv) ==
                           biu_pkg::ORD_BEFORE)
                        pos++;
                    for (k = n_entries; k > pos; k--) begin
                        tab_start[k] = tab_start[k - 1];
                        tab_stop[k]  = tab_stop[k - 1];
                    end
                    tab_start[pos] = qu;
                    tab_stop[pos]  = qv;
                    n_entries++;
                    diff         = byte_estimate(qu, qv) - removed;
                    r.size_delta = diff[54:0];
                    done         = 1;
                end
            end
            expected_words.push_back(r);
        endfunction

        // Notes one accepted input word and queues the words it must cause.
        function void note_word(logic cmd, biu_pkg::t_vo b, biu_pkg::t_vo e);
            t_table_word r;
            int          k;
            if (cmd == biu_pkg::CMD_INSERT) begin
                insert_interval(b, e);
            end else if (n_entries == 0) begin
                r      = '0;
                r.last = 1'b1;
                expected_words.push_back(r);
            end else begin
                for (k = 0; k < n_entries; k++) begin
                    r             = '0;
                    r.out_begin   = tab_start[k];
                    r.out_end     = tab_stop[k];
                    r.entry_valid = 1'b1;
                    r.last        = (k + 1 == n_entries);
                    expected_words.push_back(r);
                end
                n_entries = 0;
            end
        endfunction

        // Compares one accepted result word with the oldest expected one.
        function void check_word(t_table_word got);
            t_table_word want;
            bit          bad;
            if (expected_words.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: unexpected result word delta=%0d begin=%h end=%h",
                             $realtime, got.size_delta, got.out_begin, got.out_end);
                return;
            end
            want = expected_words.pop_front();
            bad  = (got.size_delta !== want.size_delta) ||
                   (got.out_begin !== want.out_begin) ||
                   (got.out_end !== want.out_end) ||
                   (got.entry_valid !== want.entry_valid) ||
                   (got.last !== want.last) ||
                   (got.overflow !== want.overflow);
            if (bad) begin
                error_count++;
                if (error_count <= 10)
                    $display({"%0t: mismatch exp delta=%0d begin=%h end=%h ev=%b last=%b ",
                              "ovf=%b got delta=%0d begin=%h end=%h ev=%b last=%b ovf=%b"},
                             $realtime, want.size_delta, want.out_begin, want.out_end,
                             want.entry_valid, want.last, want.overflow, got.size_delta,
                             got.out_begin, got.out_end, got.entry_valid, got.last,
                             got.overflow);
            end
        endfunction
    endclass

    logic            clk           = 1'b0;
    logic            rst_n         = 1'b0;
    logic            in_valid      = 1'b0;
    logic            in_stall;
    logic            cmd           = 1'b0;
    biu_pkg::t_vo    chunk_begin   = '0;
    biu_pkg::t_vo    chunk_end     = '0;
    logic            out_valid;
    logic            out_stall     = 1'b0;
    biu_pkg::t_delta size_delta;
    biu_pkg::t_vo    out_begin;
    biu_pkg::t_vo    out_end;
    logic            entry_valid;
    logic            last;
    logic            overflow;

    interval_scoreboard sb = new();
    int burst_left  = 1;
    int random_sent = 0;

    block_interval_union_table #(
        .TABLE_DEPTH     (TBL_DEPTH),
        .AVG_BLOCK_BYTES (AVG_BYTES)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_cmd         (cmd),
        .i_chunk_begin (chunk_begin),
        .i_chunk_end   (chunk_end),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_size_delta  (size_delta),
        .o_out_begin   (out_begin),
        .o_out_end     (out_end),
        .o_entry_valid (entry_valid),
        .o_last        (last),
        .o_overflow    (overflow)
    );

    // Free-running clock.
    initial begin
        forever #5 clk = ~clk;
    end

    // Result words are checked at the edge that accepts them.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word({size_delta, out_begin, out_end, entry_valid, last, overflow});
    end

    // The receiver stalls in spells: none, light, heavy, or a fixed duty pattern.
    initial begin
        int mode, phase;
        phase = 0;
        wait (rst_n);
        forever begin
            mode = $urandom_range(0, 3);
            repeat (50) begin
                @(posedge clk);
                phase = (phase + 1) % 9;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= (phase < 5);
                endcase
            end
        end
    end

    function automatic biu_pkg::t_vo vo(logic [47:0] blk_off, logic [15:0] in_off);
        return {blk_off, in_off};
    endfunction

    function automatic logic [15:0] pick_offset();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic biu_pkg::t_vo random_vo();
        return {$urandom(), $urandom()};
    endfunction

    // Presents one word and holds it until accepted; bursts end in a random gap.
    task automatic send_word(logic c, biu_pkg::t_vo b, biu_pkg::t_vo e);
        int gap;
        in_valid    <= 1'b1;
        cmd         <= c;
        chunk_begin <= b;
        chunk_end   <= e;
        do @(posedge clk); while (in_stall);
        sb.note_word(c, b, e);
        burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic insert_word(biu_pkg::t_vo b, biu_pkg::t_vo e);
        send_word(biu_pkg::CMD_INSERT, b, e);
    endtask

    task automatic drain_word();
        send_word(biu_pkg::CMD_DRAIN, random_vo(), random_vo());
    endtask

    // Fills the table past its depth, then merges into a full table and drains.
    task automatic fill_table();
        logic [47:0] base;
        int          i, j;
        base = 48'($urandom_range(0, 1000));
        for (j = 0; j < TBL_DEPTH + 2; j++) begin
            i = (j * 7) % (TBL_DEPTH + 2);
            insert_word(vo(base + 4 * i, pick_offset()), vo(base + 4 * i + 1, 16'h0001));
        end
        random_sent += TBL_DEPTH + 2;
        insert_word(vo(base + 4, 16'h0000), vo(base + 9, 16'h0001));
        drain_word();
        random_sent += 2;
    endtask

    // A run of clustered inserts with random content, some noise, then a drain.
    task automatic interval_sequence();
        logic [63:0]  raw;
        logic [47:0]  base, b_blk;
        biu_pkg::t_vo b, e, t;
        int           n, k;
        raw = random_vo();
        case ($urandom_range(0, 3))
            0: base = 48'd0;
            1: base = 48'hFFFF_FFFF_FFFF - 60;
            default: base = raw[47:0];
        endcase
        n = $urandom_range(2, 10);
        for (k = 0; k < n; k++) begin
            b_blk = base + $urandom_range(0, 40);
            b     = vo(b_blk, pick_offset());
            e     = vo(b_blk + $urandom_range(0, 6), pick_offset());
            if ($urandom_range(0, 9) == 0) begin
                t = b;
                b = e;
                e = t;
            end
            if ($urandom_range(0, 11) == 0) begin
                b = random_vo();
                e = random_vo();
            end
            if ($urandom_range(0, 14) == 0)
                drain_word();
            else
                insert_word(b, e);
            random_sent++;
        end
        drain_word();
        random_sent++;
    endtask

    // Reset, directed words, random words, then wait for the last results.
    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty drain, covered, merge, excluded end block, reversed, extremes.
        drain_word();
        insert_word(vo(10, 5), vo(20, 5));
        insert_word(vo(12, 0), vo(15, 3));
        insert_word(vo(20, 9), vo(25, 0));
        insert_word(vo(25, 0), vo(27, 1));
        insert_word(vo(100, 7), vo(90, 1));
        insert_word(64'd0, 64'd0);
        insert_word({64{1'b1}}, {64{1'b1}});
        insert_word(vo(48'hFFFF_FFFF_FFFF, 16'h0000), vo(48'd0, 16'hFFFF));
        insert_word(vo(5, 0), vo(30, 1));
        drain_word();
        insert_word(vo(48'hAAAA_AAAA_AAAA, 16'h5555), vo(48'hAAAA_AAAA_AAAB, 16'hAAAA));
        insert_word(vo(48'h5555_5555_5555, 16'hAAAA), vo(48'h5555_5555_5556, 16'h5555));
        drain_word();

        // Random part.
        fill_table();
        while (random_sent < 120)
            interval_sequence();

        in_valid <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/biu_pkg.sv
rtl/core/biu_cmp.sv
rtl/core/biu_acc.sv
rtl/core/block_interval_union_table.sv
tb/tb_top.sv
